[src/sms_pkg.sv]
// ----------------------------------------------------------------------------
// sms_pkg
// Shared types and constants for the SPI mode 0 slave with transmit FIFO.
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam int TX_DEPTH = 16;
  localparam int PTR_W    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int FILL_W   = $clog2(TX_DEPTH + 1);

  localparam int CMDQ_DEPTH = 2;
  localparam int CQ_PTR_W   = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE);
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BITS_PER_BYTE - 1);

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_PUSH   = 1'b1
  } req_kind_t;

  typedef struct packed {
    req_kind_t  kind;
    logic       rise;
    logic       fall;
    logic       sel;
    logic       mosi;
    logic [7:0] tx_byte;
  } cmd_t;

  typedef struct packed {
    logic [CQ_CNT_W-1:0] count;
  } cmdq_status_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
  } back_status_t;

endpackage

[src/sms_req_if.sv]
// ----------------------------------------------------------------------------
// sms_req_if
// Request channel: pin samples and transmit byte pushes.
// ----------------------------------------------------------------------------
interface sms_req_if;
  logic       valid;
  logic       ready;
  logic [0:0] req_type;
  logic       sck_level;
  logic       mosi_level;
  logic       select_level;
  logic [7:0] tx_byte;

  modport source (
    output valid, req_type, sck_level, mosi_level, select_level, tx_byte,
    input  ready
  );

  modport sink (
    input  valid, req_type, sck_level, mosi_level, select_level, tx_byte,
    output ready
  );
endinterface

[src/sms_res_if.sv]
// ----------------------------------------------------------------------------
// sms_res_if
// Result channel: MISO level, received byte and drop flag.
// ----------------------------------------------------------------------------
interface sms_res_if;
  logic       valid;
  logic       ready;
  logic       miso_level;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       tx_dropped;

  modport source (
    output valid, miso_level, rx_valid, rx_byte, tx_dropped,
    input  ready
  );

  modport sink (
    input  valid, miso_level, rx_valid, rx_byte, tx_dropped,
    output ready
  );
endinterface

[src/sms_front.sv]
// ----------------------------------------------------------------------------
// sms_front
// Accepts requests, tracks the SCK history and classifies each sample into
// rising edge, falling edge or no edge before queuing it as a command.
// ----------------------------------------------------------------------------
module sms_front
  import sms_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  sms_req_if.sink      req,
  input  logic         q_full,
  output logic         q_push,
  output cmd_t         q_cmd
);

  logic last_sck;
  logic last_sck_known;
  logic is_sample;

  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full;
  assign is_sample = (req_kind_t'(req.req_type) == REQ_SAMPLE);

  always_comb begin
    q_cmd.kind    = req_kind_t'(req.req_type);
    q_cmd.rise    = last_sck_known && !last_sck && req.sck_level;
    q_cmd.fall    = last_sck_known && last_sck && !req.sck_level;
    q_cmd.sel     = req.select_level;
    q_cmd.mosi    = req.mosi_level;
    q_cmd.tx_byte = req.tx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sck       <= 1'b0;
      last_sck_known <= 1'b0;
    end else if (q_push && is_sample) begin
      last_sck       <= req.sck_level;
      last_sck_known <= 1'b1;
    end
  end

endmodule

[src/sms_cmdq.sv]
// ----------------------------------------------------------------------------
// sms_cmdq
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module sms_cmdq
  import sms_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  cmd_t         push_cmd,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output cmd_t         head_cmd,
  output cmdq_status_t status
);

  cmd_t                entries [CMDQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr;
  logic [CQ_PTR_W-1:0] rd_ptr;
  logic [CQ_CNT_W-1:0] count;
  logic                do_pop;

  assign full         = (count == CQ_CNT_W'(CMDQ_DEPTH));
  assign head_valid   = (count != '0);
  assign head_cmd     = entries[rd_ptr];
  assign do_pop       = pop && head_valid;
  assign status.count = count;

  function automatic logic [CQ_PTR_W-1:0] cq_next(input logic [CQ_PTR_W-1:0] p);
    return (p == CQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= cq_next(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= cq_next(rd_ptr);
      end
      priority if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/sms_back.sv]
// ----------------------------------------------------------------------------
// sms_back
// Carries out commands: transmit FIFO pushes and SPI shift updates, and
// holds each result in an output register until it is transferred.
// ----------------------------------------------------------------------------
module sms_back
  import sms_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cmd_valid,
  input  cmd_t         cmd,
  output logic         cmd_pop,
  sms_res_if.source    res,
  output back_status_t status
);

  logic [7:0]           tx_queue [TX_DEPTH];
  logic [PTR_W-1:0]     rd_ptr;
  logic [PTR_W-1:0]     wr_ptr;
  logic [FILL_W-1:0]    fill;
  logic [7:0]           rx_shift;
  logic [7:0]           tx_shift;
  logic [BIT_CNT_W-1:0] bit_count;
  logic                 miso_hold;

  logic [7:0]           rx_shift_next;
  logic [7:0]           tx_shift_next;
  logic [BIT_CNT_W-1:0] bit_count_next;
  logic                 miso_hold_next;
  logic                 fifo_we;
  logic                 fifo_re;
  logic                 rx_valid_next;
  logic [7:0]           rx_byte_next;
  logic                 dropped_next;

  logic                 out_valid;
  logic                 out_miso;
  logic                 out_rx_valid;
  logic [7:0]           out_rx_byte;
  logic                 out_dropped;

  assign cmd_pop     = cmd_valid && (!out_valid || res.ready);
  assign status.fill = fill;

  assign res.valid      = out_valid;
  assign res.miso_level = out_miso;
  assign res.rx_valid   = out_rx_valid;
  assign res.rx_byte    = out_rx_byte;
  assign res.tx_dropped = out_dropped;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    rx_shift_next  = rx_shift;
    tx_shift_next  = tx_shift;
    bit_count_next = bit_count;
    miso_hold_next = miso_hold;
    fifo_we        = 1'b0;
    fifo_re        = 1'b0;
    rx_valid_next  = 1'b0;
    rx_byte_next   = '0;
    dropped_next   = 1'b0;
    unique case (cmd.kind)
      REQ_PUSH: begin
        if (fill == FILL_W'(TX_DEPTH)) begin
          dropped_next = 1'b1;
        end else begin
          fifo_we = 1'b1;
        end
      end
      REQ_SAMPLE: begin
        if (cmd.sel) begin
          if (cmd.rise) begin
            if (bit_count == '0) begin
              if (fill != '0) begin
                tx_shift_next = tx_queue[rd_ptr];
                fifo_re       = 1'b1;
              end else begin
                tx_shift_next = '0;
              end
            end
            rx_shift_next = {rx_shift[6:0], cmd.mosi};
            if (bit_count == LAST_BIT) begin
              rx_valid_next = 1'b1;
              rx_byte_next  = rx_shift_next;
            end
          end
          if (cmd.fall) begin
            tx_shift_next  = {tx_shift[6:0], 1'b0};
            bit_count_next = bit_count + 1'b1;
          end
          miso_hold_next = tx_shift_next[7];
        end else begin
          bit_count_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && fifo_we) begin
      tx_queue[wr_ptr] <= cmd.tx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      fill      <= '0;
      rx_shift  <= '0;
      tx_shift  <= '0;
      bit_count <= '0;
      miso_hold <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_pop) begin
        rx_shift  <= rx_shift_next;
        tx_shift  <= tx_shift_next;
        bit_count <= bit_count_next;
        miso_hold <= miso_hold_next;
        if (fifo_we) begin
          wr_ptr <= ptr_next(wr_ptr);
          fill   <= fill + 1'b1;
        end
        if (fifo_re) begin
          rd_ptr <= ptr_next(rd_ptr);
          fill   <= fill - 1'b1;
        end
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      out_miso     <= miso_hold_next;
      out_rx_valid <= rx_valid_next;
      out_rx_byte  <= rx_byte_next;
      out_dropped  <= dropped_next;
    end
  end

endmodule

[src/spi_mode0_slave_with_tx_fifo.sv]
// ----------------------------------------------------------------------------
// spi_mode0_slave_with_tx_fifo
// SPI mode 0 slave driven by oversampled pin samples, with a transmit FIFO
// that feeds MISO one byte per frame.
// ----------------------------------------------------------------------------
//  channel  dir  contents
//  req      in   req_type, sck_level, mosi_level, select_level, tx_byte
//  res      out  miso_level, rx_valid, rx_byte, tx_dropped
//
//  One request per cycle sustained when res is not stalled; one result per
//  request, passed through the command queue and the back output register.
//  The back unit's registered update of the shift state and FIFO sets the
//  rate; a two-entry command queue sits between front and back.
//  Reset is synchronous; it clears pointers, fill count and shift state but
//  not the FIFO storage.
//  A stalled res holds its result; req.ready falls once the queue is full.
// ----------------------------------------------------------------------------
module spi_mode0_slave_with_tx_fifo
  import sms_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  sms_req_if.sink   req,
  sms_res_if.source res
);

  logic         q_full;
  logic         q_push;
  cmd_t         q_cmd;
  logic         head_valid;
  cmd_t         head_cmd;
  logic         cmd_pop;
  cmdq_status_t cq_status;
  back_status_t bk_status;

  sms_front u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  sms_cmdq u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (cmd_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .status     (cq_status)
  );

  sms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .cmd_pop   (cmd_pop),
    .res       (res),
    .status    (bk_status)
  );

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    bk_status.fill <= FILL_W'(TX_DEPTH))
    else $error("transmit FIFO fill exceeds depth");

  a_cmdq_bound: assert property (@(posedge clk) disable iff (rst)
    cq_status.count <= CQ_CNT_W'(CMDQ_DEPTH))
    else $error("command queue count exceeds depth");

  a_ready_matches_queue: assert property (@(posedge clk) disable iff (rst)
    req.ready == (cq_status.count != CQ_CNT_W'(CMDQ_DEPTH)))
    else $error("req.ready disagrees with command queue occupancy");

  a_rx_drop_exclusive: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.rx_valid |-> !res.tx_dropped)
    else $error("result flags both a received byte and a dropped push");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    !cmd_pop |=> bk_status.fill == $past(bk_status.fill))
    else $error("FIFO fill changed without a command");
`endif

endmodule
